>>> rtl/c8x_pkg.sv
// Shared types, opcodes and constants for the CHIP-8 execute block.
// No dependencies; imported by every other file in rtl/.
package c8x_pkg;

  localparam int INSTR_BITS      = 16;
  localparam int PC_BITS         = 12;
  localparam int REG_BITS        = 8;
  localparam int REG_SEL_BITS    = 4;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int ADDR_BITS_DEF   = 12;

  localparam logic [REG_SEL_BITS-1:0] FLAG_REG  = 4'hF;
  localparam logic [INSTR_BITS-1:0]   INSTR_RET = 16'h00EE;

  // major opcodes, instr[15:12]
  localparam logic [3:0] OP_SYS     = 4'h0;
  localparam logic [3:0] OP_JP      = 4'h1;
  localparam logic [3:0] OP_CALL    = 4'h2;
  localparam logic [3:0] OP_SE_IMM  = 4'h3;
  localparam logic [3:0] OP_SNE_IMM = 4'h4;
  localparam logic [3:0] OP_SE_REG  = 4'h5;
  localparam logic [3:0] OP_LD_IMM  = 4'h6;
  localparam logic [3:0] OP_ADD_IMM = 4'h7;
  localparam logic [3:0] OP_ALU     = 4'h8;
  localparam logic [3:0] OP_SNE_REG = 4'h9;
  localparam logic [3:0] OP_LD_I    = 4'hA;
  localparam logic [3:0] OP_JP_V0   = 4'hB;

  // 8xyN function codes
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_OVERFLOW    = 2'd2,
    ST_UNDERFLOW   = 2'd3
  } c8x_status_t;

  // register writeback of one instruction
  typedef struct packed {
    logic                    dest_write;
    logic [REG_SEL_BITS-1:0] dest_reg;
    logic [REG_BITS-1:0]     dest_value;
    logic                    flag_write;
    logic                    flag_value;
  } c8x_wb_t;

  // stack, index and status side effects
  typedef struct packed {
    logic        push;
    logic        pop;
    logic        index_write;
    c8x_status_t status;
  } c8x_ctl_t;

endpackage

>>> rtl/c8x_if.sv
// Valid/ready channel interfaces for instructions in and results out.
// Depends on c8x_pkg for field widths and the status type.
interface c8x_in_if;
  import c8x_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INSTR_BITS-1:0] instr;
  logic [PC_BITS-1:0]    pc_in;
  modport source (output valid, output instr, output pc_in, input ready);
  modport sink (input valid, input instr, input pc_in, output ready);
endinterface

interface c8x_out_if;
  import c8x_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [PC_BITS-1:0]      next_pc;
  logic [PC_BITS-1:0]      index_addr;
  logic                    dest_write;
  logic [REG_SEL_BITS-1:0] dest_reg;
  logic [REG_BITS-1:0]     dest_value;
  logic                    flag_write;
  logic                    flag_value;
  c8x_status_t             status;
  modport source (output valid, output next_pc, output index_addr, output dest_write,
                  output dest_reg, output dest_value, output flag_write,
                  output flag_value, output status, input ready);
  modport sink (input valid, input next_pc, input index_addr, input dest_write,
                input dest_reg, input dest_value, input flag_write,
                input flag_value, input status, output ready);
endinterface

>>> rtl/c8x_regfile.sv
// V0..VF register file: V0..VE in a small memory with valid bits, VF in a flop.
// Two registered read ports with forwarding from the same-cycle writeback. Uses c8x_pkg.
module c8x_regfile
  import c8x_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wb_en,
  input  c8x_wb_t                 wb,
  input  logic                    rd_en,
  input  logic [REG_SEL_BITS-1:0] rd_addr_a,
  input  logic [REG_SEL_BITS-1:0] rd_addr_b,
  output logic [REG_BITS-1:0]     rd_a,
  output logic [REG_BITS-1:0]     rd_b
);

  localparam int GEN_REGS = (1 << REG_SEL_BITS) - 1;

  logic [REG_BITS-1:0] mem [0:GEN_REGS-1];
  logic [GEN_REGS-1:0] valid;
  logic [REG_BITS-1:0] vf;
  logic [REG_BITS-1:0] vf_next;
  logic                gen_wr;

  assign gen_wr = wb_en && wb.dest_write && (wb.dest_reg != FLAG_REG);

  // flag write lands after the destination write
  always_comb begin
    vf_next = vf;
    if (wb_en && wb.dest_write && (wb.dest_reg == FLAG_REG)) vf_next = wb.dest_value;
    if (wb_en && wb.flag_write) vf_next = {{(REG_BITS-1){1'b0}}, wb.flag_value};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vf    <= '0;
    end else begin
      vf <= vf_next;
      if (gen_wr) valid[wb.dest_reg] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_wr) mem[wb.dest_reg] <= wb.dest_value;
  end

  // reads see the value after this cycle's writeback
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rd_addr_a == FLAG_REG) rd_a <= vf_next;
      else if (gen_wr && (wb.dest_reg == rd_addr_a)) rd_a <= wb.dest_value;
      else if (!valid[rd_addr_a]) rd_a <= '0;
      else rd_a <= mem[rd_addr_a];

      if (rd_addr_b == FLAG_REG) rd_b <= vf_next;
      else if (gen_wr && (wb.dest_reg == rd_addr_b)) rd_b <= wb.dest_value;
      else if (!valid[rd_addr_b]) rd_b <= '0;
      else rd_b <= mem[rd_addr_b];
    end
  end

endmodule

>>> rtl/c8x_stack.sv
// Return stack: entry memory, fill count and a registered top-of-stack copy.
// Uses c8x_pkg; depth and entry width come from the top level.
module c8x_stack
  import c8x_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 pop,
  input  logic [ADDR_BITS-1:0] push_data,
  output logic [ADDR_BITS-1:0] top,
  output logic                 full,
  output logic                 empty
);

  localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
  localparam int PTR_BITS = $clog2(STACK_DEPTH);

  logic [ADDR_BITS-1:0] mem [0:STACK_DEPTH-1];
  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  count_next;
  logic [CNT_BITS-1:0]  below;

  assign full  = (count == CNT_BITS'(STACK_DEPTH));
  assign empty = (count == '0);
  assign below = count - CNT_BITS'(2);

  always_comb begin
    count_next = count;
    if (push) count_next = count + CNT_BITS'(1);
    else if (pop) count_next = count - CNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else count <= count_next;
  end

  // top tracks mem[count-1]; a pop reloads it from the entry below
  always_ff @(posedge clk) begin
    if (push) begin
      mem[count[PTR_BITS-1:0]] <= push_data;
      top                      <= push_data;
    end else if (pop && (count_next != '0)) begin
      top <= mem[below[PTR_BITS-1:0]];
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full && !pop)
    else $error("push on full stack or with pop");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop on empty stack");
`endif

endmodule

>>> rtl/c8x_alu.sv
// Combinational decode and execute of one instruction: next PC, register
// writeback and stack/index side effects. Uses c8x_pkg.
module c8x_alu
  import c8x_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
)(
  input  logic [INSTR_BITS-1:0] instr,
  input  logic [ADDR_BITS-1:0]  pc,
  input  logic [REG_BITS-1:0]   va,
  input  logic [REG_BITS-1:0]   vb,
  input  logic [ADDR_BITS-1:0]  stack_top,
  input  logic                  stack_full,
  input  logic                  stack_empty,
  output logic [ADDR_BITS-1:0]  next_pc,
  output c8x_wb_t               wb,
  output c8x_ctl_t              ctl
);

  logic [3:0]              op;
  logic [REG_SEL_BITS-1:0] x;
  logic [3:0]              n;
  logic [REG_BITS-1:0]     kk;
  logic [PC_BITS-1:0]      nnn;
  logic [ADDR_BITS-1:0]    pc_skip;
  logic [ADDR_BITS-1:0]    target;
  logic [ADDR_BITS-1:0]    target_v0;
  logic [REG_BITS:0]       sum;
  logic                    dw;
  logic                    fw;
  logic [REG_BITS-1:0]     dval;
  logic                    fval;

  assign op        = instr[15:12];
  assign x         = instr[11:8];
  assign n         = instr[3:0];
  assign kk        = instr[7:0];
  assign nnn       = instr[11:0];
  assign pc_skip   = pc + ADDR_BITS'(2);
  assign target    = ADDR_BITS'(nnn);
  // va carries V0 for Bnnn, the read port is steered at issue
  assign target_v0 = ADDR_BITS'(nnn) + ADDR_BITS'(va);
  assign sum       = {1'b0, va} + {1'b0, vb};

  always_comb begin
    next_pc         = pc;
    dw              = 1'b0;
    fw              = 1'b0;
    dval            = '0;
    fval            = 1'b0;
    ctl.push        = 1'b0;
    ctl.pop         = 1'b0;
    ctl.index_write = 1'b0;
    ctl.status      = ST_OK;

    case (op)
      OP_SYS: begin
        if (instr == INSTR_RET) begin
          if (stack_empty) begin
            ctl.status = ST_UNDERFLOW;
          end else begin
            ctl.pop = 1'b1;
            next_pc = stack_top;
          end
        end else begin
          ctl.status = ST_UNSUPPORTED;
        end
      end
      OP_JP: next_pc = target;
      OP_CALL: begin
        if (stack_full) begin
          ctl.status = ST_OVERFLOW;
        end else begin
          ctl.push = 1'b1;
          next_pc  = target;
        end
      end
      OP_SE_IMM:  if (va == kk) next_pc = pc_skip;
      OP_SNE_IMM: if (va != kk) next_pc = pc_skip;
      OP_SE_REG:  if (va == vb) next_pc = pc_skip;
      OP_SNE_REG: if (va != vb) next_pc = pc_skip;
      OP_LD_IMM: begin
        dw   = 1'b1;
        dval = kk;
      end
      OP_ADD_IMM: begin
        dw   = 1'b1;
        dval = va + kk;
      end
      OP_ALU: begin
        case (n)
          ALU_MOV: begin dw = 1'b1; dval = vb; end
          ALU_OR:  begin dw = 1'b1; dval = va | vb; end
          ALU_AND: begin dw = 1'b1; dval = va & vb; end
          ALU_XOR: begin dw = 1'b1; dval = va ^ vb; end
          ALU_ADD: begin
            dw = 1'b1; fw = 1'b1;
            dval = sum[REG_BITS-1:0];
            fval = sum[REG_BITS];
          end
          ALU_SUB: begin
            dw = 1'b1; fw = 1'b1;
            dval = va - vb;
            fval = (va >= vb);
          end
          ALU_SHR: begin
            dw = 1'b1; fw = 1'b1;
            dval = {1'b0, va[REG_BITS-1:1]};
            fval = va[0];
          end
          ALU_SUBN: begin
            dw = 1'b1; fw = 1'b1;
            dval = vb - va;
            fval = (vb >= va);
          end
          ALU_SHL: begin
            dw = 1'b1; fw = 1'b1;
            dval = {va[REG_BITS-2:0], 1'b0};
            fval = va[REG_BITS-1];
          end
          default: ctl.status = ST_UNSUPPORTED;
        endcase
      end
      OP_LD_I:  ctl.index_write = 1'b1;
      OP_JP_V0: next_pc = target_v0;
      default:  ctl.status = ST_UNSUPPORTED;
    endcase

    wb.dest_write = dw;
    wb.dest_reg   = dw ? x : '0;
    wb.dest_value = dval;
    wb.flag_write = fw;
    wb.flag_value = fval;
  end

endmodule

>>> rtl/chip8_alu_branch_execute.sv
// CHIP-8 execute block: jumps, call/return, skips, immediates, 8xyN ALU, Annn.
// Uses c8x_pkg, c8x_if, c8x_regfile, c8x_stack and c8x_alu.
//
// in_ch carries one instruction word and the already-advanced PC per transfer;
// out_ch returns one result per instruction: next PC, index register, the
// general register write, the VF flag write and a status code.
// An accepted instruction sits in an issue register (operands read from the
// register file as it enters), executes from there against the register file,
// index register and return stack once the result register is free, and lands
// in the result register. One instruction per cycle is sustained while the
// receiver keeps out_ch.ready high; state written by one instruction is seen
// by the next with no bubble, through forwarding into the operand read.
// When the receiver stalls, the result register holds and the issue register
// still takes one more instruction before in_ch.ready drops.
// Reset clears V0..VF, the index register, the stack count and both pipeline
// valid flags, so in_ch.ready is high when reset is released.
module chip8_alu_branch_execute
  import c8x_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
)(
  input  logic      clk,
  input  logic      rst,
  c8x_in_if.sink    in_ch,
  c8x_out_if.source out_ch
);

  logic                  held;
  logic [INSTR_BITS-1:0] instr_q;
  logic [PC_BITS-1:0]    pc_q;
  logic [REG_BITS-1:0]   va;
  logic [REG_BITS-1:0]   vb;
  logic [PC_BITS-1:0]    index_reg;
  logic [PC_BITS-1:0]    index_next;
  logic                  out_valid;
  logic                  fire;
  logic                  accept;
  logic [REG_SEL_BITS-1:0] rd_addr_a;

  logic [ADDR_BITS-1:0]  alu_next_pc;
  logic [ADDR_BITS-1:0]  stack_top;
  logic                  stack_full;
  logic                  stack_empty;
  c8x_wb_t               wb;
  c8x_ctl_t              ctl;

  assign fire        = held && (!out_valid || out_ch.ready);
  assign in_ch.ready = !held || fire;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;

  // Bnnn needs V0 on port A in place of Vx
  assign rd_addr_a = (in_ch.instr[15:12] == OP_JP_V0) ? '0 : in_ch.instr[11:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      out_valid <= 1'b0;
      index_reg <= '0;
    end else begin
      if (accept) held <= 1'b1;
      else if (fire) held <= 1'b0;
      if (fire) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      if (fire) index_reg <= index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      instr_q <= in_ch.instr;
      pc_q    <= in_ch.pc_in;
    end
  end

  assign index_next = ctl.index_write ? instr_q[PC_BITS-1:0] : index_reg;

  c8x_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .wb_en     (fire),
    .wb        (wb),
    .rd_en     (accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (in_ch.instr[7:4]),
    .rd_a      (va),
    .rd_b      (vb)
  );

  c8x_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && ctl.push),
    .pop       (fire && ctl.pop),
    .push_data (ADDR_BITS'(pc_q)),
    .top       (stack_top),
    .full      (stack_full),
    .empty     (stack_empty)
  );

  c8x_alu #(
    .ADDR_BITS (ADDR_BITS)
  ) u_alu (
    .instr       (instr_q),
    .pc          (ADDR_BITS'(pc_q)),
    .va          (va),
    .vb          (vb),
    .stack_top   (stack_top),
    .stack_full  (stack_full),
    .stack_empty (stack_empty),
    .next_pc     (alu_next_pc),
    .wb          (wb),
    .ctl         (ctl)
  );

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch.next_pc    <= alu_next_pc[PC_BITS-1:0];
      out_ch.index_addr <= index_next;
      out_ch.dest_write <= wb.dest_write;
      out_ch.dest_reg   <= wb.dest_reg;
      out_ch.dest_value <= wb.dest_write ? wb.dest_value : '0;
      out_ch.flag_write <= wb.flag_write;
      out_ch.flag_value <= wb.flag_write && wb.flag_value;
      out_ch.status     <= ctl.status;
    end
  end

`ifndef SYNTHESIS
  a_idle_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.dest_write |-> out_ch.dest_reg == '0 && out_ch.dest_value == '0)
    else $error("register fields set without a write");
  a_fault_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.status != ST_OK |-> !out_ch.dest_write && !out_ch.flag_write)
    else $error("faulting instruction wrote a register");
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid && !$past(ctl.push && ctl.pop))
    else $error("executed instruction lost or pushed and popped");
`endif

endmodule

>>> test/c8x_exec_checker.sv
// Scoreboard for the CHIP-8 execute block: watches both channels, predicts each result.
// Depends on c8x_pkg and the c8x_in_if / c8x_out_if interfaces.
module c8x_exec_checker
  import c8x_pkg::*;
(
  input  logic clk,
  input  logic rst,
  c8x_in_if    in_ch,
  c8x_out_if   out_ch,
  output int   errors,
  output int   pending
);

  localparam int MAX_PRINTS = 60;

  typedef struct packed {
    logic [PC_BITS-1:0] next_pc;
    logic [PC_BITS-1:0] index_addr;
    c8x_wb_t            wb;
    c8x_status_t        status;
  } exec_outcome_t;

  logic [REG_BITS-1:0] v_regs [16];
  logic [PC_BITS-1:0]  index_q;
  logic [PC_BITS-1:0]  ret_stack [STACK_DEPTH_DEF];
  int unsigned         depth;
  exec_outcome_t       outcome_q [$];

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // executes one instruction against the shadow state and returns its outcome
  function automatic exec_outcome_t exec_instr(input logic [INSTR_BITS-1:0] w,
                                               input logic [PC_BITS-1:0] pc);
    logic [3:0]          op, x, y, fn;
    logic [7:0]          kk, vx, vy, dval;
    logic [11:0]         nnn;
    logic [8:0]          sum;
    logic                dw, fw, fval;
    exec_outcome_t       r;
    op   = w[15:12];
    x    = w[11:8];
    y    = w[7:4];
    fn   = w[3:0];
    kk   = w[7:0];
    nnn  = w[11:0];
    vx   = v_regs[x];
    vy   = v_regs[y];
    dw   = 1'b0;
    fw   = 1'b0;
    dval = '0;
    fval = 1'b0;
    r    = '0;
    r.next_pc = pc;
    r.status  = ST_OK;
    case (op)
      OP_SYS: begin
        if (w == INSTR_RET) begin
          if (depth == 0) r.status = ST_UNDERFLOW;
          else begin
            depth--;
            r.next_pc = ret_stack[depth];
          end
        end else r.status = ST_UNSUPPORTED;
      end
      OP_JP: r.next_pc = nnn;
      OP_CALL: begin
        if (depth >= STACK_DEPTH_DEF) r.status = ST_OVERFLOW;
        else begin
          ret_stack[depth] = pc;
          depth++;
          r.next_pc = nnn;
        end
      end
      OP_SE_IMM:  if (vx == kk) r.next_pc = pc + 12'd2;
      OP_SNE_IMM: if (vx != kk) r.next_pc = pc + 12'd2;
      OP_SE_REG:  if (vx == vy) r.next_pc = pc + 12'd2;
      OP_SNE_REG: if (vx != vy) r.next_pc = pc + 12'd2;
      OP_LD_IMM: begin
        dw = 1'b1; dval = kk;
      end
      OP_ADD_IMM: begin
        dw = 1'b1; dval = vx + kk;
      end
      OP_ALU: begin
        case (fn)
          ALU_MOV: begin dw = 1'b1; dval = vy; end
          ALU_OR:  begin dw = 1'b1; dval = vx | vy; end
          ALU_AND: begin dw = 1'b1; dval = vx & vy; end
          ALU_XOR: begin dw = 1'b1; dval = vx ^ vy; end
          ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            dw = 1'b1; fw = 1'b1; dval = sum[7:0]; fval = sum[8];
          end
          ALU_SUB: begin
            dw = 1'b1; fw = 1'b1; dval = vx - vy; fval = (vx >= vy);
          end
          ALU_SHR: begin
            dw = 1'b1; fw = 1'b1; dval = vx >> 1; fval = vx[0];
          end
          ALU_SUBN: begin
            dw = 1'b1; fw = 1'b1; dval = vy - vx; fval = (vy >= vx);
          end
          ALU_SHL: begin
            dw = 1'b1; fw = 1'b1; dval = vx << 1; fval = vx[7];
          end
          default: r.status = ST_UNSUPPORTED;
        endcase
      end
      OP_LD_I:  index_q = nnn;
      OP_JP_V0: r.next_pc = nnn + {4'b0, v_regs[0]};
      default:  r.status = ST_UNSUPPORTED;
    endcase
    // flag lands after the destination, so VF as destination ends up as the flag
    if (dw) v_regs[x] = dval;
    if (fw) v_regs[FLAG_REG] = {7'b0, fval};
    r.wb.dest_write = dw;
    r.wb.dest_reg   = dw ? x : 4'h0;
    r.wb.dest_value = dval;
    r.wb.flag_write = fw;
    r.wb.flag_value = fval;
    r.index_addr    = index_q;
    return r;
  endfunction

  always @(posedge clk) begin
    exec_outcome_t want;
    if (rst) begin
      for (int i = 0; i < 16; i++) v_regs[i] = '0;
      for (int i = 0; i < STACK_DEPTH_DEF; i++) ret_stack[i] = '0;
      index_q = '0;
      depth   = 0;
      outcome_q.delete();
      pending <= 0;
    end else begin
      // retire before predicting: an output transfer always belongs to an older input
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (outcome_q.size() == 0) report_mismatch("result transfer with nothing outstanding");
        else begin
          want = outcome_q.pop_front();
          check_field("next_pc",    16'(out_ch.next_pc),    16'(want.next_pc));
          check_field("index_addr", 16'(out_ch.index_addr), 16'(want.index_addr));
          check_field("dest_write", 16'(out_ch.dest_write), 16'(want.wb.dest_write));
          check_field("dest_reg",   16'(out_ch.dest_reg),   16'(want.wb.dest_reg));
          check_field("dest_value", 16'(out_ch.dest_value), 16'(want.wb.dest_value));
          check_field("flag_write", 16'(out_ch.flag_write), 16'(want.wb.flag_write));
          check_field("flag_value", 16'(out_ch.flag_value), 16'(want.wb.flag_value));
          check_field("status",     16'(out_ch.status),     16'(want.status));
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        outcome_q.push_back(exec_instr(in_ch.instr, in_ch.pc_in));
      pending <= outcome_q.size();
    end
  end

endmodule

>>> test/tb_top.sv
// Top of the execute-block testbench: clock, reset, instruction stimulus and verdict.
// Depends on c8x_pkg, the channel interfaces, the block itself and c8x_exec_checker.
module tb_top;
  import c8x_pkg::*;

  localparam int N_RANDOM    = 1050;
  localparam int SEG_LEN     = 64;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_AT     = 300;
  localparam int DRAIN_AT    = 600;
  localparam int CALM_AT     = 900;
  localparam int N_DIRECTED  = 25;

  // carry, shifts, VF as destination, skip wrap, Bnnn wrap, call/return/underflow,
  // unsupported groups
  localparam logic [15:0] DIRECTED [N_DIRECTED] = '{
    16'h60FF, 16'h6101, 16'h8014, 16'h6080, 16'h800E, 16'h8016, 16'h8F15,
    16'h8F17, 16'h7FFF, 16'h3000, 16'h4000, 16'h501A, 16'h901F, 16'hAFFF,
    16'h6005, 16'hBFFF, 16'h1FFF, 16'h2ABC, 16'h00EE, 16'h00EE, 16'h00E0,
    16'h8008, 16'hC123, 16'hF155, 16'hE19E
  };

  logic clk = 1'b0;
  logic rst;
  bit   hold_req;
  bit   calm;
  int   errors;
  int   pending;
  int   quiet_cycles;

  c8x_in_if  in_ch ();
  c8x_out_if out_ch ();

  chip8_alu_branch_execute dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  c8x_exec_checker chk (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h7F;
      3: return 8'h80;
      4: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_alu_fn();
    logic [3:0] fn;
    if ($urandom_range(0, 4) == 0) begin
      fn = 4'($urandom);
      return fn;
    end
    case ($urandom_range(0, 8))
      0: return ALU_MOV;
      1: return ALU_OR;
      2: return ALU_AND;
      3: return ALU_XOR;
      4: return ALU_ADD;
      5: return ALU_SUB;
      6: return ALU_SHR;
      7: return ALU_SUBN;
      default: return ALU_SHL;
    endcase
  endfunction

  // mode 0 balanced, 1 call-heavy (fills the stack), 2 return-heavy (drains it)
  function automatic logic [15:0] pick_instr(input int mode);
    int         r, call_pct, ret_pct;
    logic [3:0] op, x, y;
    logic [11:0] nnn;
    r        = $urandom_range(0, 99);
    x        = 4'($urandom);
    y        = 4'($urandom);
    nnn      = 12'($urandom);
    call_pct = (mode == 1) ? 30 : (mode == 2) ? 5 : 6;
    ret_pct  = (mode == 2) ? 30 : (mode == 1) ? 5 : 6;
    if (r < call_pct) return {OP_CALL, nnn};
    if (r < call_pct + ret_pct) return INSTR_RET;
    op = 4'($urandom);
    case (op)
      OP_SYS: begin
        case ($urandom_range(0, 3))
          0: return 16'h00E0;
          1: return {OP_SYS, nnn};
          default: return INSTR_RET;
        endcase
      end
      OP_ALU:  return {OP_ALU, x, y, pick_alu_fn()};
      default: return {op, x, pick_byte()};
    endcase
  endfunction

  function automatic logic [11:0] pick_pc();
    logic [11:0] pc;
    pc = 12'($urandom);
    if ($urandom_range(0, 4) == 0) pc = $urandom_range(0, 1) ? 12'hFFF : 12'hFFE;
    return pc;
  endfunction

  task automatic send_instr(input logic [15:0] w, input logic [11:0] pc);
    in_ch.valid <= 1'b1;
    in_ch.instr <= w;
    in_ch.pc_in <= pc;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // no gaps while the receiver is holding off, so the pipeline backs up
    if (!calm && !hold_req && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // receiver: random stalls, one long hold-off on request, none once calm
  initial begin : receiver
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : stimulus
    int mode;
    rst         <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.instr <= '0;
    in_ch.pc_in <= '0;
    mode = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_instr(DIRECTED[i], (i % 2) ? 12'hFFF : pick_pc());

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % SEG_LEN == 0) mode = $urandom_range(0, 2);
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == DRAIN_AT) begin
        // pause until every outstanding transfer has come back
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      if (i == CALM_AT) calm = 1'b1;
      send_instr(pick_instr(mode), pick_pc());
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    if (errors == 0 && pending == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
rtl/c8x_pkg.sv
rtl/c8x_if.sv
rtl/c8x_regfile.sv
rtl/c8x_stack.sv
rtl/c8x_alu.sv
rtl/chip8_alu_branch_execute.sv
test/c8x_exec_checker.sv
test/tb_top.sv
